// File: src/sfdc_pkg.sv
// ----------------------------------------------------------------------------
// sfdc_pkg
// Shared types and constants for the stuffed frame deframer/checksum core.
// ----------------------------------------------------------------------------
package sfdc_pkg;

   localparam int MAX_FRAME_BYTES_DEF    = 4095;
   localparam int CHECK_START_OFFSET_DEF = 18;
   localparam int MIN_FRAME_BYTES_DEF    = 20;
   localparam int QUEUE_DEPTH_DEF        = 4;

   localparam int LEN_W = 12;
   localparam int SUM_W = 16;

   localparam logic [7:0] BYTE_FA  = 8'hfa;
   localparam logic [7:0] BYTE_AF  = 8'haf;
   localparam logic [7:0] BYTE_FB  = 8'hfb;
   localparam logic [7:0] BYTE_BF  = 8'hbf;
   localparam logic [7:0] ESC_FAAF = 8'h01;
   localparam logic [7:0] ESC_FBBF = 8'h02;
   localparam logic [SUM_W-1:0] SUM_ALL_ONES = 16'hffff;

   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // One decoded beat group: up to three body bytes, or a frame summary.
   typedef struct packed {
      logic             is_summary;
      logic [1:0]       nbytes;
      logic [2:0][7:0]  bytes;
      logic [LEN_W-1:0] frame_length;
      logic             too_short;
   } cmd_type;

endpackage

// File: src/sfdc_front.sv
// ----------------------------------------------------------------------------
// sfdc_front
// Delimiter hunt, escape decode and raw length count; one command per byte
// that yields results.
// ----------------------------------------------------------------------------
module sfdc_front #(
   parameter int MAX_FRAME_BYTES = sfdc_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MIN_FRAME_BYTES = sfdc_pkg::MIN_FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   input  logic              q_full,
   output logic              q_push,
   output sfdc_pkg::cmd_type q_cmd
);

   localparam int LEN_CAP_INT = (MAX_FRAME_BYTES < 4095) ? MAX_FRAME_BYTES : 4095;
   localparam logic [sfdc_pkg::LEN_W-1:0] LEN_CAP   = sfdc_pkg::LEN_W'(LEN_CAP_INT);
   localparam logic [sfdc_pkg::LEN_W-1:0] LEN_MIN   = sfdc_pkg::LEN_W'(MIN_FRAME_BYTES);
   localparam logic [sfdc_pkg::LEN_W-1:0] LEN_DELIM = sfdc_pkg::LEN_W'(2);

   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_FA   = 2'd1,
      HOLD_FB   = 2'd2,
      HOLD_FBBF = 2'd3
   } hold_type;

   hold_type                    held_ff, held_in;
   logic                        in_frame_ff, in_frame_in;
   logic [sfdc_pkg::LEN_W-1:0]  len_ff, len_in;
   sfdc_pkg::cmd_type           cmd;
   logic [1:0]                  nb;
   logic                        fresh;
   logic                        accept;

   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;

   always_comb begin
      held_in     = held_ff;
      in_frame_in = in_frame_ff;
      len_in      = len_ff;
      cmd         = '0;
      nb          = 2'd0;
      fresh       = 1'b0;
      if (!in_frame_ff) begin
         if (held_ff == HOLD_FA && req_rx_byte == sfdc_pkg::BYTE_AF) begin
            in_frame_in = 1'b1;
            held_in     = HOLD_NONE;
            len_in      = LEN_DELIM;
         end else begin
            held_in = (req_rx_byte == sfdc_pkg::BYTE_FA) ? HOLD_FA : HOLD_NONE;
         end
      end else begin
         if (len_ff < LEN_CAP) begin
            len_in = len_ff + sfdc_pkg::LEN_W'(1);
         end
         case (held_ff)
            HOLD_NONE: begin
               fresh = 1'b1;
            end
            HOLD_FA: begin
               if (req_rx_byte == sfdc_pkg::BYTE_AF) begin
                  cmd.is_summary   = 1'b1;
                  cmd.frame_length = len_in;
                  cmd.too_short    = (len_in < LEN_MIN);
                  in_frame_in      = 1'b0;
                  held_in          = HOLD_NONE;
               end else begin
                  cmd.bytes[0] = sfdc_pkg::BYTE_FA;
                  nb           = 2'd1;
                  fresh        = 1'b1;
               end
            end
            HOLD_FB: begin
               if (req_rx_byte == sfdc_pkg::BYTE_BF) begin
                  held_in = HOLD_FBBF;
               end else begin
                  cmd.bytes[0] = sfdc_pkg::BYTE_FB;
                  nb           = 2'd1;
                  fresh        = 1'b1;
               end
            end
            HOLD_FBBF: begin
               nb = 2'd2;
               if (req_rx_byte == sfdc_pkg::ESC_FAAF) begin
                  cmd.bytes[0] = sfdc_pkg::BYTE_FA;
                  cmd.bytes[1] = sfdc_pkg::BYTE_AF;
                  held_in      = HOLD_NONE;
               end else begin
                  cmd.bytes[0] = sfdc_pkg::BYTE_FB;
                  cmd.bytes[1] = sfdc_pkg::BYTE_BF;
                  held_in      = HOLD_NONE;
                  fresh        = (req_rx_byte != sfdc_pkg::ESC_FBBF);
               end
            end
            default: begin
               fresh = 1'b1;
            end
         endcase
         if (fresh) begin
            if (req_rx_byte == sfdc_pkg::BYTE_FA) begin
               held_in = HOLD_FA;
            end else if (req_rx_byte == sfdc_pkg::BYTE_FB) begin
               held_in = HOLD_FB;
            end else begin
               held_in       = HOLD_NONE;
               cmd.bytes[nb] = req_rx_byte;
               nb            = nb + 2'd1;
            end
         end
      end
      cmd.nbytes = nb;
   end

   assign q_cmd  = cmd;
   assign q_push = accept & in_frame_ff & (cmd.is_summary | (nb != 2'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= HOLD_NONE;
         in_frame_ff <= 1'b0;
         len_ff      <= '0;
      end else if (accept) begin
         held_ff     <= held_in;
         in_frame_ff <= in_frame_in;
         len_ff      <= len_in;
      end
   end

   a_hunt_hold: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (held_ff == HOLD_NONE || held_ff == HOLD_FA))
      else $error("escape prefix held while hunting");
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (len_ff <= LEN_CAP && len_ff >= LEN_DELIM))
      else $error("raw length out of range");

endmodule

// File: src/sfdc_queue.sv
// ----------------------------------------------------------------------------
// sfdc_queue
// Short command queue between the decode front and the result back end.
// ----------------------------------------------------------------------------
module sfdc_queue #(
   parameter int DEPTH = sfdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfdc_pkg::cmd_type wdata,
   input  logic              pop,
   output sfdc_pkg::cmd_type rdata,
   output logic              not_empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sfdc_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_FULL);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign rdata     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");

endmodule

// File: src/sfdc_back.sv
// ----------------------------------------------------------------------------
// sfdc_back
// Drains queued commands one result beat per cycle while rsp_ready allows; keeps the checksum
// window index and the end-around-carry sum.
// ----------------------------------------------------------------------------
module sfdc_back #(
   parameter int CHECK_START_OFFSET = sfdc_pkg::CHECK_START_OFFSET_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfdc_pkg::cmd_type             head,
   input  logic                          head_valid,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [7:0]                    rsp_data_byte,
   output logic [sfdc_pkg::SUM_W-1:0]    rsp_checksum,
   output logic [sfdc_pkg::LEN_W-1:0]    rsp_frame_length,
   output logic                          rsp_too_short,
   output logic                          rsp_last
);

   localparam int IDX_W = $clog2(CHECK_START_OFFSET + 1);
   localparam logic [IDX_W-1:0] IDX_START = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(CHECK_START_OFFSET);

   logic                          valid_ff;
   logic                          kind_ff, short_ff, last_ff;
   logic [7:0]                    data_ff;
   logic [sfdc_pkg::SUM_W-1:0]    chk_ff;
   logic [sfdc_pkg::LEN_W-1:0]    flen_ff;
   logic [1:0]                    pos_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [sfdc_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [sfdc_pkg::SUM_W:0]      sum_wide;
   logic [sfdc_pkg::SUM_W-1:0]    sum_cpl, sum_swap;
   logic [7:0]                    cur_byte;
   logic                          load, beat_last;

   assign load      = head_valid & (~valid_ff | rsp_ready);
   assign cur_byte  = head.bytes[pos_ff];
   assign beat_last = head.is_summary | (pos_ff == head.nbytes - 2'd1);
   assign pop       = load & beat_last;

   assign sum_wide = {1'b0, sum_ff} + {9'd0, cur_byte};
   always_comb begin
      sum_in = sum_ff;
      if (idx_ff >= IDX_CHECK) begin
         sum_in = sum_wide[sfdc_pkg::SUM_W] ? (sum_wide[sfdc_pkg::SUM_W-1:0] + 16'd1)
                                            : sum_wide[sfdc_pkg::SUM_W-1:0];
      end
   end

   assign sum_cpl  = (sum_ff == sfdc_pkg::SUM_ALL_ONES) ? sum_ff : ~sum_ff;
   assign sum_swap = {sum_cpl[7:0], sum_cpl[15:8]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         idx_ff   <= IDX_START;
         sum_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         if (load) begin
            if (head.is_summary) begin
               idx_ff <= IDX_START;
               sum_ff <= '0;
               pos_ff <= '0;
            end else begin
               sum_ff <= sum_in;
               if (idx_ff < IDX_CHECK) begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
               pos_ff <= beat_last ? 2'd0 : pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         last_ff <= beat_last;
         if (head.is_summary) begin
            kind_ff  <= sfdc_pkg::KIND_SUMMARY;
            data_ff  <= '0;
            chk_ff   <= sum_swap;
            flen_ff  <= head.frame_length;
            short_ff <= head.too_short;
         end else begin
            kind_ff  <= sfdc_pkg::KIND_BODY;
            data_ff  <= cur_byte;
            chk_ff   <= '0;
            flen_ff  <= '0;
            short_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_checksum     = chk_ff;
   assign rsp_frame_length = flen_ff;
   assign rsp_too_short    = short_ff;
   assign rsp_last         = last_ff;

   a_pos_in_cmd: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !head.is_summary) |-> (pos_ff < head.nbytes))
      else $error("beat position beyond command");
   a_partial_held: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 2'd0) |-> (head_valid && !head.is_summary))
      else $error("partial command left the queue head");

endmodule

// File: src/stuffed_frame_deframer_checksum_core.sv
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_checksum_core
// Path: each command is written to a queue slot, then each result beat is registered in the back end.
// Throughput: one raw byte per cycle in while the queue is not full, one result beat per cycle out while
// rsp_ready allows; an escape that decodes to three beats holds the queue head until all three are sent.
// Reset: synchronous, returns to delimiter hunt with an empty queue.
// ----------------------------------------------------------------------------
module stuffed_frame_deframer_checksum_core #(
   parameter int MAX_FRAME_BYTES    = sfdc_pkg::MAX_FRAME_BYTES_DEF,
   parameter int CHECK_START_OFFSET = sfdc_pkg::CHECK_START_OFFSET_DEF,
   parameter int MIN_FRAME_BYTES    = sfdc_pkg::MIN_FRAME_BYTES_DEF,
   parameter int QUEUE_DEPTH        = sfdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [7:0]                    rsp_data_byte,
   output logic [sfdc_pkg::SUM_W-1:0]    rsp_checksum,
   output logic [sfdc_pkg::LEN_W-1:0]    rsp_frame_length,
   output logic                          rsp_too_short,
   output logic                          rsp_last
);

   sfdc_pkg::cmd_type push_cmd, head_cmd;
   logic              push, pop, head_valid, q_full;

   sfdc_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   sfdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     (push_cmd),
      .pop       (pop),
      .rdata     (head_cmd),
      .not_empty (head_valid),
      .full      (q_full)
   );

   sfdc_back #(
      .CHECK_START_OFFSET (CHECK_START_OFFSET)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head_cmd),
      .head_valid       (head_valid),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_checksum     (rsp_checksum),
      .rsp_frame_length (rsp_frame_length),
      .rsp_too_short    (rsp_too_short),
      .rsp_last         (rsp_last)
   );

endmodule

// File: bench/stuffed_frame_deframer_checksum_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_checksum_core_tb
// Self-checking bench for the byte-stuffing deframer with frame checksum.
// A short directed table covers the hunt, the escapes, the flushes and a
// minimal frame. Random frames follow: mostly well-formed stuffed frames, some
// noise and broken ones. A behavioral deframer predicts the result beats of the
// random frames and of the untyped table rows. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module stuffed_frame_deframer_checksum_core_tb;

   localparam int LEN_CAP  = (sfdc_pkg::MAX_FRAME_BYTES_DEF < 4095) ?
                             sfdc_pkg::MAX_FRAME_BYTES_DEF : 4095;
   localparam int IDX_CAP  = (1 << sfdc_pkg::LEN_W) - 1;

   typedef enum logic [1:0] {HOLD_NONE, HOLD_FA, HOLD_FB, HOLD_FBBF} hold_type;

   typedef struct packed {
      logic                       kind;
      logic [7:0]                 data_byte;
      logic [sfdc_pkg::SUM_W-1:0] checksum;
      logic [sfdc_pkg::LEN_W-1:0] frame_length;
      logic                       too_short;
      logic                       last;
   } beat_type;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      bit         has_beat;
      beat_type   beat;
   } vec_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_kind;
   logic [7:0]                 rsp_data_byte;
   logic [sfdc_pkg::SUM_W-1:0] rsp_checksum;
   logic [sfdc_pkg::LEN_W-1:0] rsp_frame_length;
   logic                       rsp_too_short;
   logic                       rsp_last;

   stuffed_frame_deframer_checksum_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_checksum     (rsp_checksum),
      .rsp_frame_length (rsp_frame_length),
      .rsp_too_short    (rsp_too_short),
      .rsp_last         (rsp_last)
   );

   always #4 clock = ~clock;

   initial begin
      #40000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // deframer state
   bit       in_frame_m;
   hold_type held_m;
   int       raw_len_m;
   int       dec_idx_m;
   int       sum_m;

   beat_type step_beats[$];
   beat_type expected_beats[$];
   vec_type  directed_q[$];

   int err_count  = 0;
   int beat_count = 0;
   int item_count = 0;
   int rsp_stall  = 0;
   bit calm       = 1'b0;

   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_body(input logic [7:0] b);
      if (dec_idx_m >= sfdc_pkg::CHECK_START_OFFSET_DEF) begin
         sum_m += b;
         if (sum_m > 'hffff) sum_m = (sum_m & 'hffff) + 1;
      end
      if (dec_idx_m < IDX_CAP) dec_idx_m++;
      step_beats.push_back({sfdc_pkg::KIND_BODY, b, 16'h0000, 12'h000, 1'b0, 1'b0});
   endtask

   task automatic hold_or_emit(input logic [7:0] b);
      if (b == sfdc_pkg::BYTE_FA) begin
         held_m = HOLD_FA;
      end else if (b == sfdc_pkg::BYTE_FB) begin
         held_m = HOLD_FB;
      end else begin
         held_m = HOLD_NONE;
         push_body(b);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0] s;
      logic [15:0] cpl;
      beat_type    tail;
      step_beats.delete();
      if (!in_frame_m) begin
         if (held_m == HOLD_FA && b == sfdc_pkg::BYTE_AF) begin
            in_frame_m = 1'b1;
            held_m     = HOLD_NONE;
            raw_len_m  = 2;
            dec_idx_m  = 2;
            sum_m      = 0;
         end else begin
            held_m = (b == sfdc_pkg::BYTE_FA) ? HOLD_FA : HOLD_NONE;
         end
      end else begin
         if (raw_len_m < LEN_CAP) raw_len_m++;
         case (held_m)
            HOLD_FA: begin
               if (b == sfdc_pkg::BYTE_AF) begin
                  s   = sum_m[15:0];
                  cpl = (s == sfdc_pkg::SUM_ALL_ONES) ? s : ~s;
                  step_beats.push_back({sfdc_pkg::KIND_SUMMARY, 8'h00, cpl[7:0], cpl[15:8],
                                        raw_len_m[sfdc_pkg::LEN_W-1:0],
                                        raw_len_m < sfdc_pkg::MIN_FRAME_BYTES_DEF, 1'b0});
                  in_frame_m = 1'b0;
                  held_m     = HOLD_NONE;
               end else begin
                  push_body(sfdc_pkg::BYTE_FA);
                  hold_or_emit(b);
               end
            end
            HOLD_FB: begin
               if (b == sfdc_pkg::BYTE_BF) begin
                  held_m = HOLD_FBBF;
               end else begin
                  push_body(sfdc_pkg::BYTE_FB);
                  hold_or_emit(b);
               end
            end
            HOLD_FBBF: begin
               if (b == sfdc_pkg::ESC_FAAF) begin
                  push_body(sfdc_pkg::BYTE_FA);
                  push_body(sfdc_pkg::BYTE_AF);
                  held_m = HOLD_NONE;
               end else if (b == sfdc_pkg::ESC_FBBF) begin
                  push_body(sfdc_pkg::BYTE_FB);
                  push_body(sfdc_pkg::BYTE_BF);
                  held_m = HOLD_NONE;
               end else begin
                  push_body(sfdc_pkg::BYTE_FB);
                  push_body(sfdc_pkg::BYTE_BF);
                  hold_or_emit(b);
               end
            end
            default: begin
               hold_or_emit(b);
            end
         endcase
      end
      if (step_beats.size() > 0) begin
         tail = step_beats.pop_back();
         tail.last = 1'b1;
         step_beats.push_back(tail);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("mismatch on beat %0d, %s: got %0h want %0h", beat_count, what, got, want);
   endtask

   task automatic check_beat();
      beat_type want;
      beat_count++;
      if (expected_beats.size() == 0) begin
         report_mismatch("beat with nothing pending", 32'(rsp_data_byte), 32'd0);
      end else begin
         want = expected_beats.pop_front();
         if (rsp_kind !== want.kind)
            report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
         if (rsp_data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(rsp_data_byte), 32'(want.data_byte));
         if (rsp_checksum !== want.checksum)
            report_mismatch("checksum", 32'(rsp_checksum), 32'(want.checksum));
         if (rsp_frame_length !== want.frame_length)
            report_mismatch("frame_length", 32'(rsp_frame_length),
                            32'(want.frame_length));
         if (rsp_too_short !== want.too_short)
            report_mismatch("too_short", 32'(rsp_too_short), 32'(want.too_short));
         if (rsp_last !== want.last)
            report_mismatch("last", 32'(rsp_last), 32'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_beat();
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall <= idle_len();
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input bit has_beat = 1'b0, input beat_type typed_beat = '0);
      int gap;
      req_rx_byte <= b;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
      deframe_byte(b);
      if (typed) begin
         if (has_beat) expected_beats.push_back(typed_beat);
      end else begin
         while (step_beats.size() > 0) expected_beats.push_back(step_beats.pop_front());
      end
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return sfdc_pkg::BYTE_FA;
         1: return sfdc_pkg::BYTE_AF;
         2: return sfdc_pkg::BYTE_FB;
         3: return sfdc_pkg::BYTE_BF;
         4: return sfdc_pkg::ESC_FAAF;
         5: return sfdc_pkg::ESC_FBBF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_frame();
      int  len;
      int  r;
      bit  broken;
      logic [7:0] b;
      calm = ($urandom_range(0, 99) < 15);
      repeat ($urandom_range(0, 3)) send_byte(pick_raw());
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, 24);
      else len = $urandom_range(25, 45);
      broken = ($urandom_range(0, 99) < 20);
      send_byte(sfdc_pkg::BYTE_FA);
      send_byte(sfdc_pkg::BYTE_AF);
      for (int i = 0; i < len; i++) begin
         if (broken) begin
            send_byte(pick_raw());
         end else begin
            case ($urandom_range(0, 9))
               5: begin
                  send_byte(sfdc_pkg::BYTE_FB); send_byte(sfdc_pkg::BYTE_BF);
                  send_byte(sfdc_pkg::ESC_FAAF);
               end
               6: begin
                  send_byte(sfdc_pkg::BYTE_FB); send_byte(sfdc_pkg::BYTE_BF);
                  send_byte(sfdc_pkg::ESC_FBBF);
               end
               7: begin
                  b = 8'($urandom_range(0, 255));
                  send_byte(sfdc_pkg::BYTE_FA);
                  send_byte((b == sfdc_pkg::BYTE_AF) ? 8'h00 : b);
               end
               8: begin
                  send_byte(sfdc_pkg::BYTE_FB); send_byte(8'($urandom_range(0, 255)));
               end
               9: begin
                  send_byte(sfdc_pkg::BYTE_FB); send_byte(sfdc_pkg::BYTE_BF);
                  send_byte(pick_raw());
               end
               default: begin
                  b = 8'($urandom_range(0, 255));
                  if (b == sfdc_pkg::BYTE_FA || b == sfdc_pkg::BYTE_FB) b = b ^ 8'h10;
                  send_byte(b);
               end
            endcase
         end
      end
      if (!broken || $urandom_range(0, 1)) begin
         send_byte(sfdc_pkg::BYTE_FA);
         send_byte(sfdc_pkg::BYTE_AF);
      end
   endtask

   function automatic void add_row(input logic [7:0] rx, input bit typed, input bit has_beat,
                                   input beat_type beat);
      vec_type v;
      v.rx       = rx;
      v.typed    = typed;
      v.has_beat = has_beat;
      v.beat     = beat;
      directed_q.push_back(v);
   endfunction

   initial begin
      in_frame_m = 1'b0;
      held_m     = HOLD_NONE;
      raw_len_m  = 0;
      dec_idx_m  = 0;
      sum_m      = 0;

      // hunt, repeated FA, open
      add_row(8'h00,              1, 0, '0);
      add_row(8'hff,              1, 0, '0);
      add_row(sfdc_pkg::BYTE_FA,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_FA,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_AF,  1, 0, '0);
      add_row(8'h00,              1, 1,
              {sfdc_pkg::KIND_BODY, 8'h00, 16'h0000, 12'h000, 1'b0, 1'b1});
      add_row(8'hff,              1, 1,
              {sfdc_pkg::KIND_BODY, 8'hff, 16'h0000, 12'h000, 1'b0, 1'b1});
      add_row(sfdc_pkg::BYTE_FA,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_FA,  0, 0, '0);
      add_row(8'h55,              0, 0, '0);
      // escapes, unmatched tail, delimiter inside an escape
      add_row(sfdc_pkg::BYTE_FB,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_BF,  1, 0, '0);
      add_row(sfdc_pkg::ESC_FAAF, 0, 0, '0);
      add_row(sfdc_pkg::BYTE_FB,  0, 0, '0);
      add_row(sfdc_pkg::BYTE_BF,  0, 0, '0);
      add_row(sfdc_pkg::ESC_FBBF, 0, 0, '0);
      add_row(sfdc_pkg::BYTE_FB,  0, 0, '0);
      add_row(sfdc_pkg::BYTE_BF,  0, 0, '0);
      add_row(8'h33,              0, 0, '0);
      add_row(sfdc_pkg::BYTE_FB,  0, 0, '0);
      add_row(sfdc_pkg::BYTE_FA,  0, 0, '0);
      add_row(sfdc_pkg::BYTE_AF,  0, 0, '0);
      // shortest frame: nothing summed
      add_row(sfdc_pkg::BYTE_FA,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_AF,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_FA,  1, 0, '0);
      add_row(sfdc_pkg::BYTE_AF,  1, 1,
              {sfdc_pkg::KIND_SUMMARY, 8'h00, 16'hffff, 12'd4, 1'b1, 1'b1});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[k])
         send_byte(directed_q[k].rx, directed_q[k].typed, directed_q[k].has_beat,
                   directed_q[k].beat);
      req_valid <= 1'b0;
      wait_drained();

      while (item_count < 290) begin
         send_random_frame();
         if ($urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
